@@ hdl/tcas_pkg.sv @@
package tcas_pkg;

  localparam int FIELD_SPAN = 128;

  localparam logic [1:0] OP_WRITE   = 2'd0;
  localparam logic [1:0] OP_READ    = 2'd1;
  localparam logic [1:0] OP_ADVANCE = 2'd2;
  localparam logic [1:0] OP_NONE    = 2'd3;

  localparam logic [1:0] MODE_CYCLIC      = 2'd0;
  localparam logic [1:0] MODE_TOTALISTIC  = 2'd1;
  localparam logic [1:0] MODE_OUTER_TOTAL = 2'd2;
  localparam logic [1:0] MODE_GENERATIONS = 2'd3;

  localparam logic [2:0] CFG_MODE      = 3'd0;
  localparam logic [2:0] CFG_NBHD      = 3'd1;
  localparam logic [2:0] CFG_RADIUS    = 3'd2;
  localparam logic [2:0] CFG_THRESHOLD = 3'd3;
  localparam logic [2:0] CFG_RULE      = 3'd4;
  localparam logic [2:0] CFG_SURVIVE   = 3'd5;
  localparam logic [2:0] CFG_BORN      = 3'd6;
  localparam logic [2:0] CFG_STATES    = 3'd7;

  typedef struct packed {
    logic [1:0] op;
    logic [6:0] column;
    logic [6:0] row;
    logic [7:0] write_value;
  } in_word_t;

  typedef struct packed {
    logic [7:0] read_value;
    logic       generation_done;
  } out_word_t;

  typedef struct packed {
    logic clr;
    logic take;
    logic centre_rd;
    logic cap_x;
    logic mod_step;
    logic scan;
    logic cell_wr;
    logic res_rd;
    logic res_load;
  } cmd_t;

  typedef struct packed {
    logic       clr_last;
    logic       mod_last;
    logic       off_last;
    logic       cell_last;
    logic       out_free;
    logic [1:0] op;
  } stat_t;

endpackage

@@ hdl/toroidal_cellular_automaton_step_unit.sv @@
// Toroidal cellular automaton over a COLUMNS x ROWS grid of 8-bit cells held in two
// planes of one on-chip memory. After reset the block clears the current plane, one
// cell a cycle, and holds in_ready low meanwhile; configuration writes are taken at
// any time. A write word goes from its take straight to the response; a read word
// first passes a read-data state (registered memory read). An advance word sweeps
// every cell through one memory read port: per cell a centre read, a capture, a
// bit-serial (x+1) mod max(num_states, 2), (2R+1)^2 neighbour reads, a drain state
// and a write-back, where R is the cyclic radius capped at MAX_RADIUS, or 1 in the
// binary and generations modes. One word is processed at a time; the response sits
// in an output register while the next word is taken.
module toroidal_cellular_automaton_step_unit #(
  parameter int COLUMNS    = 128,
  parameter int ROWS       = 128,
  parameter int MAX_RADIUS = 3
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic [2:0]          cfg_index,
  input  logic [17:0]         cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  tcas_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_ready,
  output tcas_pkg::out_word_t out_word
);
  import tcas_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  tcas_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  tcas_datapath #(
    .COLUMNS    (COLUMNS),
    .ROWS       (ROWS),
    .MAX_RADIUS (MAX_RADIUS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_word   (in_word),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

`ifndef SYNTHESIS
  a_done_no_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.generation_done |-> out_word.read_value == 8'd0)
    else $error("advance response carries read data");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second word taken while one is in flight");

  a_clear_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !in_ready)
    else $error("word taken during clearing pass");
`endif

endmodule

@@ hdl/tcas_ctrl.sv @@
module tcas_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  tcas_pkg::stat_t stat,
  output tcas_pkg::cmd_t  cmd
);
  import tcas_pkg::*;

  typedef enum logic [9:0] {
    ST_CLEAR  = 10'b0000000001,
    ST_IDLE   = 10'b0000000010,
    ST_RDATA  = 10'b0000000100,
    ST_CENTRE = 10'b0000001000,
    ST_CAP    = 10'b0000010000,
    ST_MOD    = 10'b0000100000,
    ST_SCAN   = 10'b0001000000,
    ST_DRAIN  = 10'b0010000000,
    ST_WRITE  = 10'b0100000000,
    ST_RESP   = 10'b1000000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    cmd = '0;
    unique case (state)
      ST_CLEAR: begin
        cmd.clr = 1'b1;
        if (stat.clr_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.take = 1'b1;
          priority if (stat.op == OP_READ) state_next = ST_RDATA;
          else if (stat.op == OP_ADVANCE) state_next = ST_CENTRE;
          else state_next = ST_RESP;
        end
      end
      ST_RDATA: begin
        cmd.res_rd = 1'b1;
        state_next = ST_RESP;
      end
      ST_CENTRE: begin
        cmd.centre_rd = 1'b1;
        state_next = ST_CAP;
      end
      ST_CAP: begin
        cmd.cap_x = 1'b1;
        state_next = ST_MOD;
      end
      ST_MOD: begin
        cmd.mod_step = 1'b1;
        if (stat.mod_last) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.off_last) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        state_next = ST_WRITE;
      end
      ST_WRITE: begin
        cmd.cell_wr = 1'b1;
        state_next = stat.cell_last ? ST_RESP : ST_CENTRE;
      end
      ST_RESP: begin
        if (stat.out_free) begin
          cmd.res_load = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

endmodule

@@ hdl/tcas_datapath.sv @@
module tcas_datapath #(
  parameter int COLUMNS    = 128,
  parameter int ROWS       = 128,
  parameter int MAX_RADIUS = 3
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic [2:0]          cfg_index,
  input  logic [17:0]         cfg_data,
  input  tcas_pkg::in_word_t  in_word,
  input  tcas_pkg::cmd_t      cmd,
  output tcas_pkg::stat_t     stat,
  output logic                out_valid,
  input  logic                out_ready,
  output tcas_pkg::out_word_t out_word
);
  import tcas_pkg::*;

  localparam int CW = $clog2(COLUMNS);
  localparam int RW = $clog2(ROWS);
  localparam int OW = $clog2(MAX_RADIUS + 1) + 1;
  localparam int NW = $clog2((2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1) + 1);
  localparam int AW = 1 + RW + CW;
  localparam int CA = CW + OW;
  localparam int RA = RW + OW;

  // configuration
  logic [1:0]  mode;
  logic        nbhd;
  logic [1:0]  radius;
  logic [5:0]  threshold;
  logic [17:0] rule_bits;
  logic [8:0]  survive_mask;
  logic [8:0]  born_mask;
  logic [7:0]  num_states;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= MODE_CYCLIC;
      nbhd         <= 1'b0;
      radius       <= 2'd1;
      threshold    <= 6'd3;
      rule_bits    <= 18'd736;
      survive_mask <= 9'd12;
      born_mask    <= 9'd8;
      num_states   <= 8'd2;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_MODE:      mode         <= cfg_data[1:0];
        CFG_NBHD:      nbhd         <= cfg_data[0];
        CFG_RADIUS:    radius       <= cfg_data[1:0];
        CFG_THRESHOLD: threshold    <= cfg_data[5:0];
        CFG_RULE:      rule_bits    <= cfg_data;
        CFG_SURVIVE:   survive_mask <= cfg_data[8:0];
        CFG_BORN:      born_mask    <= cfg_data[8:0];
        CFG_STATES:    num_states   <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  logic [7:0] n_eff, high;
  assign n_eff = (num_states < 8'd2) ? 8'd2 : num_states;
  assign high  = n_eff - 8'd1;

  // address wrap tables for the input fields
  logic [CW-1:0] col_tab [FIELD_SPAN];
  logic [RW-1:0] row_tab [FIELD_SPAN];
  for (genvar g = 0; g < FIELD_SPAN; g++) begin : g_tab
    assign col_tab[g] = CW'(g % COLUMNS);
    assign row_tab[g] = RW'(g % ROWS);
  end

  // control and sweep registers
  logic              plane;
  logic [RW+CW-1:0]  clr_cnt;
  logic [CW-1:0]     ccol;
  logic [RW-1:0]     crow;
  logic signed [OW-1:0] dx, dy;
  logic [7:0]        x;
  logic [7:0]        rem;
  logic [8:0]        dvd;
  logic [3:0]        mcnt;
  logic [NW-1:0]     cnt;
  logic              tag_v, tag_c;
  out_word_t         res;

  // effective radius
  logic [OW-2:0] reff_cyc, reff;
  logic signed [OW-1:0] rs;
  assign reff_cyc = (4'(radius) > 4'(MAX_RADIUS)) ? (OW-1)'(MAX_RADIUS) : (OW-1)'(radius);
  assign reff     = (mode == MODE_CYCLIC) ? reff_cyc : (OW-1)'(1);
  assign rs       = $signed({1'b0, reff});

  // neighbour address
  logic signed [CA-1:0] cs;
  logic signed [RA-1:0] rsum;
  logic [CW-1:0] ncol;
  logic [RW-1:0] nrow;
  always_comb begin
    cs   = $signed(CA'(ccol)) + CA'(dx);
    rsum = $signed(RA'(crow)) + RA'(dy);
    if (cs < 0) cs = cs + CA'(COLUMNS);
    else if (cs >= $signed(CA'(COLUMNS))) cs = cs - CA'(COLUMNS);
    if (rsum < 0) rsum = rsum + RA'(ROWS);
    else if (rsum >= $signed(RA'(ROWS))) rsum = rsum - RA'(ROWS);
    ncol = cs[CW-1:0];
    nrow = rsum[RW-1:0];
  end

  // which offsets count
  logic signed [OW-1:0] ax, ay;
  logic [OW:0] reach;
  logic is_centre, filt;
  always_comb begin
    ax = (dx < 0) ? -dx : dx;
    ay = (dy < 0) ? -dy : dy;
    reach = (OW+1)'(ax) + (OW+1)'(ay);
    is_centre = (dx == 0) && (dy == 0);
    unique case (mode)
      MODE_CYCLIC:      filt = !(nbhd && (reach > (OW+1)'(reff)));
      MODE_GENERATIONS: filt = !is_centre;
      default:          filt = !is_centre && !(nbhd && (dx != 0) && (dy != 0));
    endcase
  end

  // memory
  logic [7:0]    mem [2**AW];
  logic [7:0]    q;
  logic          we, re;
  logic [AW-1:0] waddr, raddr;
  logic [7:0]    wdata, wv_cl, nxt;
  logic          take_wr;

  assign take_wr = cmd.take && (in_word.op == OP_WRITE);
  assign wv_cl   = (in_word.write_value > high) ? high : in_word.write_value;

  always_comb begin
    we = cmd.clr || cmd.cell_wr || take_wr;
    priority if (cmd.clr) begin
      waddr = {1'b0, clr_cnt};
      wdata = 8'd0;
    end else if (cmd.cell_wr) begin
      waddr = {~plane, crow, ccol};
      wdata = nxt;
    end else begin
      waddr = {plane, row_tab[in_word.row], col_tab[in_word.column]};
      wdata = wv_cl;
    end
    re = cmd.take || cmd.centre_rd || cmd.scan;
    priority if (cmd.take) raddr = {plane, row_tab[in_word.row], col_tab[in_word.column]};
    else if (cmd.centre_rd) raddr = {plane, crow, ccol};
    else raddr = {plane, nrow, ncol};
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) q <= mem[raddr];
  end

  // next cell value
  logic [4:0] idx;
  logic       match;
  always_comb begin
    idx = (mode == MODE_TOTALISTIC) ? 5'(cnt) + 5'(x[0]) : 5'({cnt, x[0]});
    unique case (mode)
      MODE_CYCLIC: begin
        match = (q == rem);
        nxt = (9'(cnt) >= 9'(threshold)) ? rem : x;
      end
      MODE_GENERATIONS: begin
        match = (q == high);
        if (x != 8'd0) nxt = survive_mask[cnt[3:0]] ? x : x - 8'd1;
        else nxt = born_mask[cnt[3:0]] ? high : 8'd0;
      end
      default: begin
        match = q[0];
        nxt = {7'd0, rule_bits[idx]};
      end
    endcase
  end

  logic [8:0] rsh;
  assign rsh = {rem, dvd[8]};

  always_ff @(posedge clk) begin
    if (rst) begin
      plane   <= 1'b0;
      clr_cnt <= '0;
      tag_v   <= 1'b0;
    end else begin
      if (cmd.clr) clr_cnt <= clr_cnt + 1'b1;
      tag_v <= cmd.scan;
      if (cmd.cell_wr && stat.cell_last) plane <= ~plane;
    end
  end

  always_ff @(posedge clk) begin
    tag_c <= filt;
    if (cmd.take) begin
      ccol <= '0;
      crow <= '0;
      res  <= '0;
    end
    if (cmd.res_rd) res <= '{read_value: q, generation_done: 1'b0};
    if (cmd.centre_rd) begin
      dx  <= -rs;
      dy  <= -rs;
      cnt <= '0;
    end
    if (cmd.cap_x) begin
      x    <= q;
      rem  <= 8'd0;
      dvd  <= {1'b0, q} + 9'd1;
      mcnt <= 4'd0;
    end
    if (cmd.mod_step) begin
      rem  <= (rsh >= {1'b0, n_eff}) ? 8'(rsh - {1'b0, n_eff}) : rsh[7:0];
      dvd  <= {dvd[7:0], 1'b0};
      mcnt <= mcnt + 4'd1;
    end
    if (cmd.scan) begin
      if (dx == rs) begin
        dx <= -rs;
        dy <= dy + 1'b1;
      end else begin
        dx <= dx + 1'b1;
      end
    end
    if (tag_v && tag_c && match) cnt <= cnt + 1'b1;
    if (cmd.cell_wr) begin
      if (ccol == CW'(COLUMNS - 1)) begin
        ccol <= '0;
        crow <= (crow == RW'(ROWS - 1)) ? '0 : crow + 1'b1;
      end else begin
        ccol <= ccol + 1'b1;
      end
      if (stat.cell_last) res <= '{read_value: 8'd0, generation_done: 1'b1};
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.res_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) out_word <= res;
  end

  always_comb begin
    stat.clr_last  = &clr_cnt;
    stat.mod_last  = (mcnt == 4'd8);
    stat.off_last  = (dx == rs) && (dy == rs);
    stat.cell_last = (ccol == CW'(COLUMNS - 1)) && (crow == RW'(ROWS - 1));
    stat.out_free  = !out_valid || out_ready;
    stat.op        = in_word.op;
  end

endmodule
